/* src/efla_pkg.sv */
// ----------------------------------------------------------------------------
// efla_pkg: shared types and codes of the extent free-list allocator
// Request opcodes, response status codes, the cell command set and the
// per-cell flag bundle that neighbouring cells and the controller read.
// ----------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

    // Width of every block-address field on the item channels
    localparam int FIELD_W = 24;

    // Request opcodes
    localparam logic [1:0] OPC_FORMAT  = 2'd0;
    localparam logic [1:0] OPC_ALLOC   = 2'd1;
    localparam logic [1:0] OPC_RELEASE = 2'd2;
    localparam logic [1:0] OPC_NOP     = 2'd3;

    // Response status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NO_FIT = 2'd1;
    localparam logic [1:0] STS_FULL   = 2'd2;

    // Command broadcast to every cell of the chain
    typedef enum logic [3:0] {
        CELL_HOLD,      // keep contents
        CELL_RIP_FIT,   // ripple start of first extent that fits toward cell 0
        CELL_RIP_END,   // ripple end of last touching extent toward cell 0
        CELL_CLEAR,     // empty the table
        CELL_FORMAT,    // head cell takes the whole data area, rest empty
        CELL_TRIM,      // trim the granted extent, or drop it when used up
        CELL_MERGE,     // first touching extent grows to the merged range
        CELL_DROP,      // remove the extent just after the merged one
        CELL_INSERT     // open a gap in sorted place and write the new range
    } cell_op_t;

    // Per-cell status seen by neighbours and the controller
    typedef struct packed {
        logic touch;    // extent touches or overlaps the release range
        logic ins;      // empty, or extent ends at or after the range start
        logic exact;    // granted extent is used up by this allocation
        logic dup;      // extent lies inside the merged range, after its head
    } cell_flags_t;

endpackage

`default_nettype wire

/* src/efla_if.sv */
// ----------------------------------------------------------------------------
// efla_if: item channels of the extent free-list allocator
// Request and response channels, valid/ready handshake with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface efla_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [23:0] start_block;
    logic [23:0] length;

    modport source (output valid, output opcode, output start_block, output length,
                    input ready);
    modport sink   (input valid, input opcode, input start_block, input length,
                    output ready);
endinterface

interface efla_rsp_if;
    logic        valid;
    logic        ready;
    logic [23:0] granted_start;
    logic [23:0] granted_length;
    logic [1:0]  status;

    modport source (output valid, output granted_start, output granted_length,
                    output status, input ready);
    modport sink   (input valid, input granted_start, input granted_length,
                    input status, output ready);
endinterface

`default_nettype wire

/* src/efla_cell.sv */
// ----------------------------------------------------------------------------
// efla_cell: one entry of the free-extent chain
// Holds one extent, evaluates it against the broadcast command, shifts
// contents to and from its neighbours and carries the ripple bus one hop.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_cell
    import efla_pkg::*;
#(
    parameter int BLOCK_BITS = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_op_t              op,
    input  wire logic                  drop,
    input  wire logic                  head,
    input  wire logic [BLOCK_BITS-1:0] s,
    input  wire logic [BLOCK_BITS-1:0] e,
    input  wire logic [BLOCK_BITS-1:0] gs,
    input  wire logic [BLOCK_BITS-1:0] fmt_start,
    input  wire logic [BLOCK_BITS-1:0] fmt_len,
    input  wire logic [((BLOCK_BITS > FIELD_W) ? BLOCK_BITS : FIELD_W):0] len,
    input  wire logic [BLOCK_BITS:0]   ne,
    input  wire logic                  prev_valid,
    input  wire logic [BLOCK_BITS-1:0] prev_start,
    input  wire logic [BLOCK_BITS-1:0] prev_length,
    input  wire cell_flags_t           prev_flags,
    input  wire logic                  next_valid,
    input  wire logic [BLOCK_BITS-1:0] next_start,
    input  wire logic [BLOCK_BITS-1:0] next_length,
    input  wire cell_flags_t           next_flags,
    input  wire logic                  next_bus_hit,
    input  wire logic [BLOCK_BITS:0]   next_bus_val,
    output logic                       valid,
    output logic [BLOCK_BITS-1:0]      start,
    output logic [BLOCK_BITS-1:0]      length,
    output cell_flags_t                flags,
    output logic                       bus_hit,
    output logic [BLOCK_BITS:0]        bus_val
);

    localparam int BB = BLOCK_BITS;
    localparam int CW = ((BB > FIELD_W) ? BB : FIELD_W) + 1;

    logic          valid_reg, valid_next;
    logic [BB-1:0] start_reg, start_next;
    logic [BB-1:0] length_reg, length_next;
    logic          bus_hit_reg, bus_hit_next;
    logic [BB:0]   bus_val_reg, bus_val_next;

    logic [BB:0]   end_x;
    logic          touch, ins, fit, winner, exact, dup, lo, last;
    logic [BB-1:0] ns;

    // local evaluation of the extent
    assign end_x  = {1'b0, start_reg} + {1'b0, length_reg};
    assign touch  = valid_reg && (end_x >= {1'b0, s}) && (start_reg <= e);
    assign ins    = !valid_reg || (end_x >= {1'b0, s});
    assign fit    = valid_reg && (CW'(length_reg) >= len);
    assign winner = fit && (start_reg == gs);
    assign exact  = winner && (CW'(length_reg) == len);
    assign dup    = valid_reg && (start_reg > s) && ({1'b0, start_reg} <= ne);
    assign lo     = touch && !prev_flags.touch;
    assign last   = touch && !next_flags.touch;
    assign ns     = (start_reg < s) ? start_reg : s;

    assign flags  = '{touch: touch, ins: ins, exact: exact, dup: dup};

    // next contents
    always_comb
    begin
        valid_next   = valid_reg;
        start_next   = start_reg;
        length_next  = length_reg;
        bus_hit_next = bus_hit_reg;
        bus_val_next = bus_val_reg;
        unique case (op)
            CELL_HOLD:
            begin
            end
            CELL_RIP_FIT:
            begin
                bus_hit_next = fit || next_bus_hit;
                bus_val_next = fit ? {1'b0, start_reg} : next_bus_val;
            end
            CELL_RIP_END:
            begin
                bus_hit_next = last || next_bus_hit;
                bus_val_next = last ? end_x : next_bus_val;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            CELL_FORMAT:
            begin
                valid_next  = head;
                start_next  = fmt_start;
                length_next = fmt_len;
            end
            CELL_TRIM:
            begin
                if (drop)
                begin
                    if (!valid_reg || start_reg >= gs)
                    begin
                        valid_next  = next_valid;
                        start_next  = next_start;
                        length_next = next_length;
                    end
                end
                else if (winner)
                begin
                    start_next  = start_reg + BB'(len);
                    length_next = length_reg - BB'(len);
                end
            end
            CELL_MERGE:
            begin
                if (lo)
                begin
                    start_next  = ns;
                    length_next = BB'(ne - {1'b0, ns});
                end
            end
            CELL_DROP:
            begin
                if (!valid_reg || start_reg > s)
                begin
                    valid_next  = next_valid;
                    start_next  = next_start;
                    length_next = next_length;
                end
            end
            CELL_INSERT:
            begin
                if (ins)
                begin
                    if (prev_flags.ins)
                    begin
                        valid_next  = prev_valid;
                        start_next  = prev_start;
                        length_next = prev_length;
                    end
                    else
                    begin
                        valid_next  = 1'b1;
                        start_next  = s;
                        length_next = BB'(len);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // extent and ripple payload
    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        length_reg  <= length_next;
        bus_hit_reg <= bus_hit_next;
        bus_val_reg <= bus_val_next;
    end

    assign valid   = valid_reg;
    assign start   = start_reg;
    assign length  = length_reg;
    assign bus_hit = bus_hit_reg;
    assign bus_val = bus_val_reg;

endmodule

`default_nettype wire

/* src/extent_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// extent_free_list_allocator: first-fit extent allocator with coalescing
// A chain of MAX_EXTENTS cells holds the sorted free-extent table; a small
// controller broadcasts commands and collects results through a ripple bus.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  req     | in  | valid/ready      | opcode, start_block, length
//  rsp     | out | valid/ready      | granted_start, granted_length, status
//  cfg     | in  | cfg_we only      | cfg_index, cfg_data
//
//  Format: apply, then done, which loads the response register; zero-length,
//  clipped-away and no-op items go straight to done.
//  Allocate and release: ripple along the cell chain, then decide and done on
//  no fit or a full table, decide, apply and done on a grant or an insert, and
//  decide, apply, drop until no swallowed extent is left, and done on a merge.
//  One item in flight; req is ready again once its response is registered,
//  and a response still waiting on rsp holds the item in its last cycle.
//  Reset empties the table, volume_blocks = 0, first_data_block = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_free_list_allocator
    import efla_pkg::*;
#(
    parameter int MAX_EXTENTS = 64,
    parameter int BLOCK_BITS  = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data,
    efla_req_if.sink         req,
    efla_rsp_if.source       rsp
);

    localparam int BB    = BLOCK_BITS;
    localparam int CW    = ((BB > FIELD_W) ? BB : FIELD_W) + 1;
    localparam int CNT_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int IU_W  = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] LIMIT   = CW'((64'd1 << BB) - 64'd1);
    localparam logic [BB:0]   LIMIT_X = {1'b0, {BB{1'b1}}};

    // configuration register indexes
    localparam logic CFG_VOLUME = 1'b0;
    localparam logic CFG_FIRST  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RIPPLE,
        ST_DECIDE,
        ST_APPLY,
        ST_DROP,
        ST_DONE
    } state_t;

    state_t          state_reg;
    cell_op_t        act_reg;
    logic [1:0]      opc_reg;
    logic [BB-1:0]   s_reg, e_reg, gs_reg;
    logic [CW-1:0]   len_reg;
    logic [BB:0]     ne_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IU_W-1:0] in_use_reg;
    logic [23:0]     vol_reg, fdb_reg;
    logic [23:0]     res_gs_reg, res_gl_reg;
    logic [1:0]      res_st_reg;
    logic            out_valid_reg;
    logic [23:0]     out_gs_reg, out_gl_reg;
    logic [1:0]      out_st_reg;

    // chain wiring
    logic            c_valid   [MAX_EXTENTS];
    logic [BB-1:0]   c_start   [MAX_EXTENTS];
    logic [BB-1:0]   c_length  [MAX_EXTENTS];
    cell_flags_t     c_flags   [MAX_EXTENTS];
    logic            c_bus_hit [MAX_EXTENTS];
    logic [BB:0]     c_bus_val [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] exact_vec, dup_vec;
    logic            exact_any, dup_any;

    cell_op_t        cell_op;
    logic            fmt_ok;
    logic [BB-1:0]   fmt_start, fmt_len;

    // request decode
    logic            accept;
    logic [CW-1:0]   rq_s, rq_len, rq_room, rq_clip, rq_e;
    logic            rq_trivial;
    logic [BB:0]     e_x, max_end, ne_calc;

    assign fmt_ok    = vol_reg > fdb_reg;
    assign fmt_start = BB'(CW'(fdb_reg));
    assign fmt_len   = BB'(CW'(vol_reg) - CW'(fdb_reg));

    assign accept     = req.valid && req.ready;
    assign rq_s       = CW'(req.start_block) & LIMIT;
    assign rq_len     = CW'(req.length);
    assign rq_trivial = (rq_s >= LIMIT) || (rq_len == '0);
    assign rq_room    = LIMIT - rq_s;
    assign rq_clip    = (rq_len > rq_room) ? rq_room : rq_len;
    assign rq_e       = rq_s + rq_clip;

    // merged end of a release: furthest of range end and last touching extent
    assign e_x     = {1'b0, e_reg};
    assign max_end = (c_bus_val[0] > e_x) ? c_bus_val[0] : e_x;
    assign ne_calc = (max_end > LIMIT_X) ? LIMIT_X : max_end;

    // command to the chain
    always_comb
    begin
        unique case (state_reg)
            ST_RIPPLE: cell_op = act_reg;
            ST_APPLY:  cell_op = act_reg;
            ST_DROP:   cell_op = dup_any ? CELL_DROP : CELL_HOLD;
            default:   cell_op = CELL_HOLD;
        endcase
    end

    // cell chain
    for (genvar i = 0; i < MAX_EXTENTS; i++)
    begin : g_cell
        logic          p_valid, n_valid, n_bus_hit;
        logic [BB-1:0] p_start, p_length, n_start, n_length;
        cell_flags_t   p_flags, n_flags;
        logic [BB:0]   n_bus_val;

        if (i == 0)
        begin : g_head
            assign p_valid  = 1'b0;
            assign p_start  = '0;
            assign p_length = '0;
            assign p_flags  = '0;
        end
        else
        begin : g_body
            assign p_valid  = c_valid[i-1];
            assign p_start  = c_start[i-1];
            assign p_length = c_length[i-1];
            assign p_flags  = c_flags[i-1];
        end

        if (i == MAX_EXTENTS - 1)
        begin : g_tail
            assign n_valid   = 1'b0;
            assign n_start   = '0;
            assign n_length  = '0;
            assign n_flags   = '0;
            assign n_bus_hit = 1'b0;
            assign n_bus_val = '0;
        end
        else
        begin : g_link
            assign n_valid   = c_valid[i+1];
            assign n_start   = c_start[i+1];
            assign n_length  = c_length[i+1];
            assign n_flags   = c_flags[i+1];
            assign n_bus_hit = c_bus_hit[i+1];
            assign n_bus_val = c_bus_val[i+1];
        end

        efla_cell #(
            .BLOCK_BITS (BB)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .op           (cell_op),
            .drop         (exact_any),
            .head         ((i == 0) ? 1'b1 : 1'b0),
            .s            (s_reg),
            .e            (e_reg),
            .gs           (gs_reg),
            .fmt_start    (fmt_start),
            .fmt_len      (fmt_len),
            .len          (len_reg),
            .ne           (ne_reg),
            .prev_valid   (p_valid),
            .prev_start   (p_start),
            .prev_length  (p_length),
            .prev_flags   (p_flags),
            .next_valid   (n_valid),
            .next_start   (n_start),
            .next_length  (n_length),
            .next_flags   (n_flags),
            .next_bus_hit (n_bus_hit),
            .next_bus_val (n_bus_val),
            .valid        (c_valid[i]),
            .start        (c_start[i]),
            .length       (c_length[i]),
            .flags        (c_flags[i]),
            .bus_hit      (c_bus_hit[i]),
            .bus_val      (c_bus_val[i])
        );

        assign exact_vec[i] = c_flags[i].exact;
        assign dup_vec[i]   = c_flags[i].dup;
    end

    assign exact_any = |exact_vec;
    assign dup_any   = |dup_vec;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg <= '0;
            fdb_reg <= 24'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOLUME: vol_reg <= cfg_data;
                CFG_FIRST:  fdb_reg <= cfg_data;
                default:    vol_reg <= vol_reg;
            endcase
        end
    end

    // controller and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= CELL_HOLD;
            opc_reg       <= OPC_NOP;
            s_reg         <= '0;
            e_reg         <= '0;
            gs_reg        <= '0;
            len_reg       <= '0;
            ne_reg        <= '0;
            cnt_reg       <= '0;
            in_use_reg    <= '0;
            res_gs_reg    <= '0;
            res_gl_reg    <= '0;
            res_st_reg    <= STS_OK;
            out_valid_reg <= 1'b0;
            out_gs_reg    <= '0;
            out_gl_reg    <= '0;
            out_st_reg    <= STS_OK;
        end
        else
        begin
            // in the done state the response register is reloaded below
            if (rsp.valid && rsp.ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        opc_reg    <= req.opcode;
                        cnt_reg    <= '0;
                        res_gs_reg <= '0;
                        res_gl_reg <= '0;
                        res_st_reg <= STS_OK;
                        unique case (req.opcode)
                            OPC_FORMAT:
                            begin
                                act_reg    <= fmt_ok ? CELL_FORMAT : CELL_CLEAR;
                                in_use_reg <= fmt_ok ? IU_W'(1) : '0;
                                state_reg  <= ST_APPLY;
                            end
                            OPC_ALLOC:
                            begin
                                len_reg <= rq_len;
                                act_reg <= CELL_RIP_FIT;
                                if (rq_len == '0)
                                    state_reg <= ST_DONE;
                                else
                                    state_reg <= ST_RIPPLE;
                            end
                            OPC_RELEASE:
                            begin
                                s_reg   <= BB'(rq_s);
                                e_reg   <= BB'(rq_e);
                                len_reg <= rq_clip;
                                act_reg <= CELL_RIP_END;
                                if (rq_trivial)
                                    state_reg <= ST_DONE;
                                else
                                    state_reg <= ST_RIPPLE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RIPPLE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MAX_EXTENTS - 1))
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (opc_reg == OPC_ALLOC)
                    begin
                        if (c_bus_hit[0])
                        begin
                            gs_reg     <= c_bus_val[0][BB-1:0];
                            res_gs_reg <= 24'(c_bus_val[0][BB-1:0]);
                            res_gl_reg <= 24'(len_reg);
                            act_reg    <= CELL_TRIM;
                            state_reg  <= ST_APPLY;
                        end
                        else
                        begin
                            res_st_reg <= STS_NO_FIT;
                            state_reg  <= ST_DONE;
                        end
                    end
                    else if (c_bus_hit[0])
                    begin
                        ne_reg    <= ne_calc;
                        act_reg   <= CELL_MERGE;
                        state_reg <= ST_APPLY;
                    end
                    else if (in_use_reg == IU_W'(MAX_EXTENTS))
                    begin
                        res_st_reg <= STS_FULL;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        in_use_reg <= in_use_reg + 1'b1;
                        act_reg    <= CELL_INSERT;
                        state_reg  <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (act_reg == CELL_TRIM && exact_any)
                        in_use_reg <= in_use_reg - 1'b1;
                    if (act_reg == CELL_MERGE)
                        state_reg <= ST_DROP;
                    else
                        state_reg <= ST_DONE;
                end
                ST_DROP:
                begin
                    // one swallowed extent leaves the chain per cycle
                    if (dup_any)
                        in_use_reg <= in_use_reg - 1'b1;
                    else
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_gs_reg    <= res_gs_reg;
                        out_gl_reg    <= res_gl_reg;
                        out_st_reg    <= res_st_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.granted_start  = out_gs_reg;
    assign rsp.granted_length = out_gl_reg;
    assign rsp.status         = out_st_reg;

endmodule

`default_nettype wire

/* tb/extent_free_list_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extent_free_list_allocator_tb: self-checking bench for the extent allocator
// A queue of pending requests feeds a clocked driver. A clocked monitor checks
// every response against a local first-fit table model that is updated as
// each request is accepted. Phases use different volume geometries, and
// random idle bursts fall on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_free_list_allocator_tb;
    import efla_pkg::*;

    localparam int NCELL = 64;
    localparam logic [63:0] BLK_TOP = 64'hFF_FFFF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int CFG_VOLUME = 0;
    localparam int CFG_FIRST = 1;

    typedef struct {
        logic [1:0]  opcode;
        logic [23:0] start_block;
        logic [23:0] length;
    } request_t;

    typedef struct {
        logic [23:0] gs;
        logic [23:0] gl;
        logic [1:0]  st;
    } grant_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [23:0] cfg_data;

    efla_req_if req_ch ();
    efla_rsp_if rsp_ch ();

    extent_free_list_allocator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
    );

    // Local copy of the free table and volume geometry
    logic [63:0] free_start [NCELL];
    logic [63:0] free_len [NCELL];
    int          n_free;
    logic [63:0] vol_blocks;
    logic [63:0] data_first;

    request_t pending_reqs [$];
    grant_t   expected_grants [$];
    grant_t   live_allocs [$];

    int  errors;
    int  n_checked;
    int  n_full;
    int  n_nofit;
    int  send_gap;
    int  stall_gap;
    bit  quiet;
    bit  req_taken;
    longint cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Remove count entries from index from, closing the hole
    function automatic void drop_extents(int from, int count);
        int i;
        if (count == 0 || from >= n_free) return;
        if (count > n_free - from) count = n_free - from;
        for (i = from; i + count < n_free; i++) begin
            free_start[i] = free_start[i + count];
            free_len[i] = free_len[i + count];
        end
        for (i = n_free - count; i < n_free; i++) begin
            free_start[i] = 0;
            free_len[i] = 0;
        end
        n_free -= count;
    endfunction

    // Work out the response to one request and update the table
    function automatic grant_t apply_request(request_t r);
        grant_t g;
        logic [63:0] s, len, e, ns, ne, last_end;
        int i, lo, hi;
        g.gs = '0;
        g.gl = '0;
        g.st = STS_OK;
        len = 64'(r.length);
        case (r.opcode)
            OPC_FORMAT:
            begin
                for (i = 0; i < NCELL; i++) begin
                    free_start[i] = 0;
                    free_len[i] = 0;
                end
                n_free = 0;
                if (vol_blocks > data_first) begin
                    free_start[0] = data_first & BLK_TOP;
                    free_len[0] = (vol_blocks - data_first) & BLK_TOP;
                    n_free = 1;
                end
            end
            OPC_ALLOC:
            begin
                if (len != 0) begin
                    g.st = STS_NO_FIT;
                    for (i = 0; i < n_free; i++) begin
                        if (free_len[i] >= len) begin
                            g.gs = free_start[i][23:0];
                            g.gl = len[23:0];
                            g.st = STS_OK;
                            free_start[i] = (free_start[i] + len) & BLK_TOP;
                            free_len[i] -= len;
                            if (free_len[i] == 0) drop_extents(i, 1);
                            break;
                        end
                    end
                end
            end
            OPC_RELEASE:
            begin
                s = 64'(r.start_block);
                if (s < BLK_TOP && len != 0) begin
                    if (len > BLK_TOP - s) len = BLK_TOP - s;
                    e = s + len;
                    lo = 0;
                    while (lo < n_free && free_start[lo] + free_len[lo] < s) lo++;
                    hi = lo;
                    while (hi < n_free && free_start[hi] <= e) hi++;
                    if (hi == lo) begin
                        if (n_free >= NCELL) g.st = STS_FULL;
                        else
                        begin
                            for (i = n_free; i > lo; i--) begin
                                free_start[i] = free_start[i - 1];
                                free_len[i] = free_len[i - 1];
                            end
                            free_start[lo] = s;
                            free_len[lo] = len;
                            n_free++;
                        end
                    end
                    else
                    begin
                        ns = free_start[lo] < s ? free_start[lo] : s;
                        last_end = free_start[hi - 1] + free_len[hi - 1];
                        ne = last_end > e ? last_end : e;
                        if (ne > BLK_TOP) ne = BLK_TOP;
                        free_start[lo] = ns;
                        free_len[lo] = ne - ns;
                        drop_extents(lo + 1, hi - lo - 1);
                    end
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // Request driver: changes on the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end
        else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_taken) begin
            req_ch.valid <= 1'b1;
        end
        else if (pending_reqs.size() > 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 11) - 1;
                req_ch.valid <= 1'b0;
            end
            else
            begin
                req_ch.valid <= 1'b1;
                req_ch.opcode <= pending_reqs[0].opcode;
                req_ch.start_block <= pending_reqs[0].start_block;
                req_ch.length <= pending_reqs[0].length;
            end
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // Response back-pressure in bursts
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_gap > 0) begin
            stall_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(1, 11) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Accepted requests: predict the response
    always @(posedge clk) begin
        request_t r;
        grant_t g;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            r.opcode = req_ch.opcode;
            r.start_block = req_ch.start_block;
            r.length = req_ch.length;
            void'(pending_reqs.pop_front());
            g = apply_request(r);
            expected_grants.push_back(g);
            if (r.opcode == OPC_ALLOC && g.st == STS_OK && g.gl != 0)
                live_allocs.push_back(g);
            if (r.opcode == OPC_FORMAT) live_allocs.delete();
        end
    end

    // Response monitor
    always @(posedge clk) begin
        grant_t g;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected response: start %0h length %0h status %0d",
                       rsp_ch.granted_start, rsp_ch.granted_length, rsp_ch.status);
                errors++;
            end
            else
            begin
                g = expected_grants.pop_front();
                n_checked++;
                if (g.st == STS_FULL) n_full++;
                if (g.st == STS_NO_FIT) n_nofit++;
                if (rsp_ch.granted_start !== g.gs) begin
                    $error("granted_start: expected %0h actual %0h", g.gs,
                           rsp_ch.granted_start);
                    errors++;
                end
                if (rsp_ch.granted_length !== g.gl) begin
                    $error("granted_length: expected %0h actual %0h", g.gl,
                           rsp_ch.granted_length);
                    errors++;
                end
                if (rsp_ch.status !== g.st) begin
                    $error("status: expected %0d actual %0d", g.st, rsp_ch.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] op, logic [23:0] sb, logic [23:0] len);
        request_t r;
        r.opcode = op;
        r.start_block = sb;
        r.length = len;
        pending_reqs.push_back(r);
        while (pending_reqs.size() > 3) @(posedge clk);
    endtask

    // Wait until the block is idle with nothing outstanding
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_grants.size() != 0 || req_ch.valid)
            @(posedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(int idx, logic [23:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx[0];
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VOLUME) vol_blocks = 64'(value);
        else data_first = 64'(value);
    endtask

    // One random request; scatter mode fills the table with small islands
    task automatic random_req(bit scatter, logic [23:0] base);
        grant_t g;
        int pick, k, off, span;
        pick = $urandom_range(0, 99);
        span = (vol_blocks > data_first) ? int'(vol_blocks - data_first) : 0;
        if (span > 4096) span = 4096;
        if (scatter && pick < 55) begin
            push_req(OPC_RELEASE, base + 24'($urandom_range(0, 150) * 3),
                     24'($urandom_range(1, 2)));
        end
        else if (pick < 45 && live_allocs.size() > 0) begin
            k = $urandom_range(0, live_allocs.size() - 1);
            g = live_allocs[k];
            live_allocs.delete(k);
            if ($urandom_range(0, 3) == 0 && g.gl > 1) begin
                off = $urandom_range(0, int'(g.gl) - 1);
                push_req(OPC_RELEASE, g.gs + 24'(off),
                         24'($urandom_range(1, int'(g.gl) - off)));
            end
            else push_req(OPC_RELEASE, g.gs, g.gl);
        end
        else if (pick < 80) begin
            k = $urandom_range(0, 9);
            if (k == 0) push_req(OPC_ALLOC, 24'($urandom), 24'($urandom));
            else if (k == 1) push_req(OPC_ALLOC, 24'($urandom), 24'd0);
            else push_req(OPC_ALLOC, 24'($urandom), 24'($urandom_range(1, 40)));
        end
        else if (pick < 94) begin
            if ($urandom_range(0, 3) == 0)
                push_req(OPC_RELEASE, 24'($urandom), 24'($urandom));
            else
                push_req(OPC_RELEASE, 24'(data_first) + 24'($urandom_range(0, span)),
                         24'($urandom_range(0, 24)));
        end
        else if (pick < 97) begin
            push_req(OPC_NOP, 24'($urandom), 24'($urandom));
        end
        else
        begin
            push_req(OPC_FORMAT, 24'($urandom), 24'($urandom));
        end
    endtask

    task automatic run_phase(logic [23:0] vol, logic [23:0] first, int count,
                             bit scatter, logic [23:0] base);
        int i;
        drain();
        write_reg(CFG_VOLUME, vol);
        write_reg(CFG_FIRST, first);
        push_req(OPC_FORMAT, 24'd0, 24'd0);
        for (i = 0; i < count; i++) random_req(scatter, base);
    endtask

    initial begin
        int i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OPC_NOP;
        req_ch.start_block = '0;
        req_ch.length = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        n_checked = 0;
        n_full = 0;
        n_nofit = 0;
        send_gap = 0;
        stall_gap = 0;
        quiet = 1'b0;
        req_taken = 1'b0;
        cycles = 0;
        n_free = 0;
        vol_blocks = 0;
        data_first = 1;
        for (i = 0; i < NCELL; i++) begin
            free_start[i] = 0;
            free_len[i] = 0;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset geometry gives an empty volume
        push_req(OPC_FORMAT, 24'd0, 24'd0);
        push_req(OPC_ALLOC, 24'd0, 24'd1);
        push_req(OPC_RELEASE, 24'd0, 24'd0);
        push_req(OPC_RELEASE, 24'hFF_FFFF, 24'd5);
        push_req(OPC_RELEASE, 24'hFF_FFF0, 24'hFF_FFFF);
        push_req(OPC_RELEASE, 24'hFF_FFF0, 24'd2);
        push_req(OPC_NOP, 24'hFF_FFFF, 24'hFF_FFFF);
        drain();
        write_reg(CFG_VOLUME, 24'd1000);
        write_reg(CFG_FIRST, 24'd10);
        push_req(OPC_FORMAT, 24'd0, 24'd0);
        push_req(OPC_ALLOC, 24'd0, 24'd0);
        push_req(OPC_ALLOC, 24'd0, 24'd5);
        push_req(OPC_ALLOC, 24'd0, 24'd2000);
        push_req(OPC_ALLOC, 24'd0, 24'd20);
        push_req(OPC_RELEASE, 24'd10, 24'd3);
        push_req(OPC_RELEASE, 24'd13, 24'd2);
        push_req(OPC_RELEASE, 24'd2000, 24'd4);
        push_req(OPC_RELEASE, 24'd5, 24'd2100);
        push_req(OPC_ALLOC, 24'd0, 24'd990);
        push_req(OPC_ALLOC, 24'd0, 24'hFF_FFFF);

        // Random phases over several volume geometries
        run_phase(24'hFF_FFFF, 24'd0, 280, 1'b0, 24'd0);
        run_phase(24'd0, 24'hFF_FFFF, 260, 1'b1, 24'hFF_FC00);
        run_phase(24'd4096, 24'd1, 280, 1'b0, 24'd0);
        run_phase(24'd0, 24'd0, 260, 1'b1, 24'd100);
        run_phase(24'($urandom), 24'($urandom_range(0, 5000)), 280, 1'b0, 24'd0);
        run_phase(24'hFF_FFFF, 24'hFF_FFFF, 150, 1'b1, 24'h80_0000);
        drain();
        quiet = 1'b1;
        run_phase(24'd2000, 24'd16, 260, 1'b0, 24'd0);
        drain();

        $display("checked %0d responses across 9 volume geometries", n_checked);
        $display("%0d no-fit and %0d table-full responses seen", n_nofit, n_full);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
